// File: sv/spg_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the softened point gravity source.
package spg_pkg;

  localparam int unsigned CfgIdxBits = 8;

  typedef enum logic [1:0] {
    CFG_GRAV = 2'd0,
    CFG_SOFT = 2'd1,
    CFG_RHO  = 2'd2,
    CFG_DT   = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic vld;
    logic sat;
  } ctl_t;

endpackage

// File: sv/spg_sqrt.sv
`timescale 1ns / 1ps
// Pipelined integer square root, one root bit per stage.
module spg_sqrt #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     vld_i,
  input  logic [2*WORD_BITS+1:0]   rad_i,
  output logic                     vld_o,
  output logic [2*WORD_BITS+1:0]   rad_o,
  output logic [WORD_BITS:0]       root_o
);
  localparam int unsigned SW = 2 * WORD_BITS + 2;
  localparam int unsigned QW = WORD_BITS + 1;

  logic [QW-1:0] vld_q;
  logic [SW-1:0] rem_s [QW];
  logic [SW-1:0] rad_s [QW];
  logic [QW-1:0] rt_s  [QW];
  logic [SW-1:0] rem_d [QW];
  logic [QW-1:0] rt_d  [QW];
  logic [SW-1:0] rem_q [QW];
  logic [SW-1:0] rad_q [QW];
  logic [QW-1:0] rt_q  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_in
    if (k == 0) begin : g_first
      assign rem_s[k] = rad_i;
      assign rad_s[k] = rad_i;
      assign rt_s[k]  = '0;
    end else begin : g_next
      assign rem_s[k] = rem_q[k-1];
      assign rad_s[k] = rad_q[k-1];
      assign rt_s[k]  = rt_q[k-1];
    end
  end

  always_comb begin
    logic [SW-1:0] cand;
    for (int k = 0; k < QW; k++) begin
      cand = (SW'(rt_s[k]) << (QW - k)) | (SW'(1) << (2 * (QW - 1 - k)));
      if (rem_s[k] >= cand) begin
        rem_d[k] = rem_s[k] - cand;
        rt_d[k]  = rt_s[k] | (QW'(1) << (QW - 1 - k));
      end else begin
        rem_d[k] = rem_s[k];
        rt_d[k]  = rt_s[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[QW-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < QW; k++) begin
      rem_q[k] <= rem_d[k];
      rt_q[k]  <= rt_d[k];
      rad_q[k] <= rad_s[k];
    end
  end

  assign vld_o  = vld_q[QW-1];
  assign rad_o  = rad_q[QW-1];
  assign root_o = rt_q[QW-1];

endmodule

// File: sv/spg_div.sv
`timescale 1ns / 1ps
// Denominator multiply and pipelined restoring divide for the force factor.
module spg_div #(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   vld_i,
  input  logic [2*WORD_BITS+1:0] rad_i,
  input  logic [WORD_BITS:0]     root_i,
  input  logic [WORD_BITS-1:0]   gm_i,
  output spg_pkg::ctl_t          ctl_o,
  output logic [WORD_BITS-1:0]   f_o
);
  import spg_pkg::*;

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned F  = FRAC_BITS;
  localparam int unsigned SW = 2 * W + 2;
  localparam int unsigned QW = W + 1;
  localparam int unsigned DW = SW + QW;
  localparam int unsigned CW = DW + W;
  localparam int unsigned QS = W + 1;

  logic [1:0]              m_vld_q;
  logic [W+QW-1:0]         plo_q;
  logic [SW-W+QW-1:0]      phi_q;
  logic [DW-1:0]           den_q;

  logic [QS-1:0] dv_q;
  logic [CW-1:0] rem_s [QS];
  logic [DW-1:0] dd_s  [QS];
  logic [QS-1:0] qt_s  [QS];
  logic [CW-1:0] rem_d [QS];
  logic [QS-1:0] qt_d  [QS];
  logic [CW-1:0] rem_q [QS];
  logic [DW-1:0] dd_q  [QS];
  logic [QS-1:0] qt_q  [QS];
  logic          ovf;

  for (genvar j = 0; j < QS; j++) begin : g_in
    if (j == 0) begin : g_first
      assign rem_s[j] = CW'(gm_i) << (3 * F);
      assign dd_s[j]  = den_q;
      assign qt_s[j]  = '0;
    end else begin : g_next
      assign rem_s[j] = rem_q[j-1];
      assign dd_s[j]  = dd_q[j-1];
      assign qt_s[j]  = qt_q[j-1];
    end
  end

  always_comb begin
    logic [CW-1:0] cand;
    for (int j = 0; j < QS; j++) begin
      cand = CW'(dd_s[j]) << (W - j);
      if (rem_s[j] >= cand) begin
        rem_d[j] = rem_s[j] - cand;
        qt_d[j]  = qt_s[j] | (QS'(1) << (W - j));
      end else begin
        rem_d[j] = rem_s[j];
        qt_d[j]  = qt_s[j];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= '0;
      dv_q    <= '0;
    end else begin
      m_vld_q <= {m_vld_q[0], vld_i};
      dv_q    <= {dv_q[QS-2:0], m_vld_q[1]};
    end
  end

  always_ff @(posedge clk_i) begin
    plo_q <= (W+QW)'(rad_i[W-1:0]) * (W+QW)'(root_i);
    phi_q <= (SW-W+QW)'(rad_i[SW-1:W]) * (SW-W+QW)'(root_i);
    den_q <= DW'(plo_q) + (DW'(phi_q) << W);
    for (int j = 0; j < QS; j++) begin
      rem_q[j] <= rem_d[j];
      qt_q[j]  <= qt_d[j];
      dd_q[j]  <= dd_s[j];
    end
  end

  assign ovf       = qt_q[QS-1][W];
  assign f_o       = ovf ? '1 : qt_q[QS-1][W-1:0];
  assign ctl_o.vld = dv_q[QS-1];
  assign ctl_o.sat = ovf;

endmodule

// File: sv/spg_kick.sv
`timescale 1ns / 1ps
// Momentum and energy kick pipeline with saturating fixed-point arithmetic.
module spg_kick #(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  spg_pkg::ctl_t        ctl_i,
  input  logic [WORD_BITS-1:0] f_i,
  input  logic [WORD_BITS-1:0] rho_i,
  input  logic [WORD_BITS-1:0] dt_i,
  input  logic [WORD_BITS-1:0] pos_i [3],
  input  logic [WORD_BITS-1:0] mom_i [3],
  input  logic [WORD_BITS-1:0] energy_i,
  output spg_pkg::ctl_t        ctl_o,
  output logic [WORD_BITS-1:0] mom_o [3],
  output logic [WORD_BITS-1:0] energy_o
);
  import spg_pkg::*;

  localparam int unsigned W = WORD_BITS;
  localparam int unsigned F = FRAC_BITS;
  localparam int unsigned NS = 9;

  function automatic logic [W:0] umulq(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [2*W-1:0] p;
    logic [W:0]     res;
    p = ((2*W)'(a) * (2*W)'(b)) >> F;
    if (|p[2*W-1:W]) res = {1'b1, {W{1'b1}}};
    else res = {1'b0, p[W-1:0]};
    return res;
  endfunction

  function automatic logic [W:0] smulq(input logic na, input logic [W-1:0] ma,
                                       input logic nb, input logic [W-1:0] mb);
    logic [2*W-1:0] p;
    logic [2*W-1:0] cap;
    logic           neg;
    logic [W:0]     res;
    neg = na ^ nb;
    p   = ((2*W)'(ma) * (2*W)'(mb)) >> F;
    cap = neg ? ((2*W)'(1) << (W - 1)) : (((2*W)'(1) << (W - 1)) - (2*W)'(1));
    if (p > cap) begin
      res[W] = 1'b1;
      p      = cap;
    end else begin
      res[W] = 1'b0;
    end
    res[W-1:0] = neg ? (W'(0) - p[W-1:0]) : p[W-1:0];
    return res;
  endfunction

  function automatic logic [W-1:0] mag(input logic [W-1:0] a);
    return a[W-1] ? (W'(0) - a) : a;
  endfunction

  function automatic logic [W+1:0] ext(input logic [W-1:0] a);
    return {{2{a[W-1]}}, a};
  endfunction

  function automatic logic [W:0] satw(input logic [W+1:0] v);
    logic [W:0] res;
    if (v[W+1:W-1] == 3'b000 || v[W+1:W-1] == 3'b111) res = {1'b0, v[W-1:0]};
    else res = {1'b1, v[W+1], {(W-1){~v[W+1]}}};
    return res;
  endfunction

  logic [NS-1:0] vld_q, sat_q;

  logic [W:0] k1r, k2r, d6r, g7r, h8r, e9r;
  logic [W:0] p3r [3];
  logic [W:0] m4r [3];
  logic [W:0] t5r [3];

  logic [W-1:0] k1_q, k2_q, d6_q, g7_q, h8_q;
  logic [W-1:0] f1_q, f2_q, f3_q, f4_q, f5_q, f6_q;
  logic [W-1:0] e1_q, e2_q, e3_q, e4_q, e5_q, e6_q, e7_q, e8_q, e9_q;
  logic [W-1:0] pos1_q [3];
  logic [W-1:0] pos2_q [3];
  logic [W-1:0] pos3_q [3];
  logic [W-1:0] pos4_q [3];
  logic [W-1:0] mom1_q [3];
  logic [W-1:0] mom2_q [3];
  logic [W-1:0] mom3_q [3];
  logic [W-1:0] p3_q [3];
  logic [W-1:0] m4_q [3];
  logic [W-1:0] t5_q [3];
  logic [W-1:0] m5_q [3];
  logic [W-1:0] m6_q [3];
  logic [W-1:0] m7_q [3];
  logic [W-1:0] m8_q [3];
  logic [W-1:0] m9_q [3];

  always_comb begin
    k1r = umulq(rho_i, f_i);
    k2r = umulq(k1_q, dt_i);
    for (int i = 0; i < 3; i++) begin
      p3r[i] = smulq(1'b0, k2_q, pos2_q[i][W-1], mag(pos2_q[i]));
      m4r[i] = satw(ext(mom3_q[i]) - ext(p3_q[i]));
      t5r[i] = smulq(m4_q[i][W-1], mag(m4_q[i]), pos4_q[i][W-1], mag(pos4_q[i]));
    end
    d6r = satw(ext(t5_q[0]) + ext(t5_q[1]) + ext(t5_q[2]));
    g7r = smulq(d6_q[W-1], mag(d6_q), 1'b0, f6_q);
    h8r = smulq(g7_q[W-1], mag(g7_q), 1'b0, dt_i);
    e9r = satw(ext(e8_q) - ext(h8_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      sat_q <= '0;
    end else begin
      vld_q    <= {vld_q[NS-2:0], ctl_i.vld};
      sat_q[0] <= ctl_i.sat | k1r[W];
      sat_q[1] <= sat_q[0] | k2r[W];
      sat_q[2] <= sat_q[1] | p3r[0][W] | p3r[1][W] | p3r[2][W];
      sat_q[3] <= sat_q[2] | m4r[0][W] | m4r[1][W] | m4r[2][W];
      sat_q[4] <= sat_q[3] | t5r[0][W] | t5r[1][W] | t5r[2][W];
      sat_q[5] <= sat_q[4] | d6r[W];
      sat_q[6] <= sat_q[5] | g7r[W];
      sat_q[7] <= sat_q[6] | h8r[W];
      sat_q[8] <= sat_q[7] | e9r[W];
    end
  end

  always_ff @(posedge clk_i) begin
    k1_q <= k1r[W-1:0];
    k2_q <= k2r[W-1:0];
    d6_q <= d6r[W-1:0];
    g7_q <= g7r[W-1:0];
    h8_q <= h8r[W-1:0];
    e9_q <= e9r[W-1:0];
    f1_q <= f_i;
    f2_q <= f1_q;
    f3_q <= f2_q;
    f4_q <= f3_q;
    f5_q <= f4_q;
    f6_q <= f5_q;
    e1_q <= energy_i;
    e2_q <= e1_q;
    e3_q <= e2_q;
    e4_q <= e3_q;
    e5_q <= e4_q;
    e6_q <= e5_q;
    e7_q <= e6_q;
    e8_q <= e7_q;
    for (int i = 0; i < 3; i++) begin
      pos1_q[i] <= pos_i[i];
      pos2_q[i] <= pos1_q[i];
      pos3_q[i] <= pos2_q[i];
      pos4_q[i] <= pos3_q[i];
      mom1_q[i] <= mom_i[i];
      mom2_q[i] <= mom1_q[i];
      mom3_q[i] <= mom2_q[i];
      p3_q[i]   <= p3r[i][W-1:0];
      m4_q[i]   <= m4r[i][W-1:0];
      t5_q[i]   <= t5r[i][W-1:0];
      m5_q[i]   <= m4_q[i];
      m6_q[i]   <= m5_q[i];
      m7_q[i]   <= m6_q[i];
      m8_q[i]   <= m7_q[i];
      m9_q[i]   <= m8_q[i];
    end
  end

  assign ctl_o.vld = vld_q[NS-1];
  assign ctl_o.sat = sat_q[NS-1];
  assign mom_o     = m9_q;
  assign energy_o  = e9_q;

endmodule

// File: sv/softened_point_gravity_source.sv
`timescale 1ns / 1ps
// Top level of the softened point-mass gravity kick pipeline.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+-----------------------------------------
//  input    | start / busy                 | pos_*_i, mom_*_in_i, energy_in_i
//  result   | done_o strobe                | mom_*_out_o, energy_out_o, saturated_o
//  config   | cfg_valid_i / cfg_ready_o    | cfg_index_i, cfg_data_i
//
// One item enters per cycle; busy stays low and cfg_ready_o stays high.
// The pipeline depth comes from the bit-per-stage square root and divide
// chains plus nine kick stages.
// Reset clears valid bits and loads the register reset values.
// The result strobe cannot be held off, so the pipeline never stalls.
module softened_point_gravity_source #(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [WORD_BITS-1:0]              pos_x_i,
  input  logic [WORD_BITS-1:0]              pos_y_i,
  input  logic [WORD_BITS-1:0]              pos_z_i,
  input  logic [WORD_BITS-1:0]              mom_x_in_i,
  input  logic [WORD_BITS-1:0]              mom_y_in_i,
  input  logic [WORD_BITS-1:0]              mom_z_in_i,
  input  logic [WORD_BITS-1:0]              energy_in_i,
  output logic                              done_o,
  output logic [WORD_BITS-1:0]              mom_x_out_o,
  output logic [WORD_BITS-1:0]              mom_y_out_o,
  output logic [WORD_BITS-1:0]              mom_z_out_o,
  output logic [WORD_BITS-1:0]              energy_out_o,
  output logic                              saturated_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [spg_pkg::CfgIdxBits-1:0]    cfg_index_i,
  input  logic [WORD_BITS-1:0]              cfg_data_i
);
  import spg_pkg::*;

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned F  = FRAC_BITS;
  localparam int unsigned SW = 2 * W + 2;
  localparam int unsigned LF = 2 * W + 6;
  localparam int unsigned PW = 7 * W;
  localparam logic [W-1:0] OneRst  = W'(64'd1 << F);
  localparam logic [W-1:0] SoftRst = W'(((64'd1 << F) + 64'd5) / 64'd10);

  logic [W-1:0] grav_strength_q, softening_length_q, ambient_density_q, time_step_q;

  logic              v1_q, v2_q;
  logic [2*W-1:0]    sx_q, sy_q, sz_q, se_q;
  logic [SW-1:0]     s_q;
  logic [PW-1:0]     pay_q [LF];
  logic [PW-1:0]     pay;

  logic              sq_vld;
  logic [SW-1:0]     sq_rad;
  logic [W:0]        sq_root;
  ctl_t              div_ctl, kick_ctl;
  logic [W-1:0]      f_val;
  logic [W-1:0]      pos_v [3];
  logic [W-1:0]      mom_v [3];
  logic [W-1:0]      mom_r [3];
  logic [W-1:0]      energy_r;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_strength_q    <= OneRst;
      softening_length_q <= SoftRst;
      ambient_density_q  <= OneRst;
      time_step_q        <= '0;
    end else if (cfg_valid_i && cfg_index_i[CfgIdxBits-1:2] == '0) begin
      case (cfg_reg_e'(cfg_index_i[1:0]))
        CFG_GRAV: grav_strength_q    <= cfg_data_i;
        CFG_SOFT: softening_length_q <= cfg_data_i;
        CFG_RHO:  ambient_density_q  <= cfg_data_i;
        CFG_DT:   time_step_q        <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= start;
      v2_q <= v1_q;
    end
  end

  // squares of signed words are nonnegative and fit 2W bits
  always_ff @(posedge clk_i) begin
    sx_q <= (2*W)'($signed(pos_x_i)) * (2*W)'($signed(pos_x_i));
    sy_q <= (2*W)'($signed(pos_y_i)) * (2*W)'($signed(pos_y_i));
    sz_q <= (2*W)'($signed(pos_z_i)) * (2*W)'($signed(pos_z_i));
    se_q <= (2*W)'(softening_length_q) * (2*W)'(softening_length_q);
    s_q  <= SW'(sx_q) + SW'(sy_q) + SW'(sz_q) + SW'(se_q);
    pay_q[0] <= {energy_in_i, mom_z_in_i, mom_y_in_i, mom_x_in_i, pos_z_i, pos_y_i, pos_x_i};
    for (int i = 1; i < LF; i++) begin
      pay_q[i] <= pay_q[i-1];
    end
  end

  assign pay = pay_q[LF-1];
  for (genvar i = 0; i < 3; i++) begin : g_unpack
    assign pos_v[i] = pay[i*W +: W];
    assign mom_v[i] = pay[(3+i)*W +: W];
  end

  spg_sqrt #(
    .WORD_BITS(W)
  ) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (v2_q),
    .rad_i  (s_q),
    .vld_o  (sq_vld),
    .rad_o  (sq_rad),
    .root_o (sq_root)
  );

  spg_div #(
    .WORD_BITS(W),
    .FRAC_BITS(F)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (sq_vld),
    .rad_i  (sq_rad),
    .root_i (sq_root),
    .gm_i   (grav_strength_q),
    .ctl_o  (div_ctl),
    .f_o    (f_val)
  );

  spg_kick #(
    .WORD_BITS(W),
    .FRAC_BITS(F)
  ) u_kick (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (div_ctl),
    .f_i      (f_val),
    .rho_i    (ambient_density_q),
    .dt_i     (time_step_q),
    .pos_i    (pos_v),
    .mom_i    (mom_v),
    .energy_i (pay[6*W +: W]),
    .ctl_o    (kick_ctl),
    .mom_o    (mom_r),
    .energy_o (energy_r)
  );

  assign done_o       = kick_ctl.vld;
  assign saturated_o  = kick_ctl.sat;
  assign mom_x_out_o  = mom_r[0];
  assign mom_y_out_o  = mom_r[1];
  assign mom_z_out_o  = mom_r[2];
  assign energy_out_o = energy_r;

endmodule
